// ===== design/lgu_pkg.sv =====
// ----------------------------------------------------------------------------
// lgu_pkg
// shared types, register indexes, reset values and the exp table builder for
// the log-odds grid update block
// ----------------------------------------------------------------------------
package lgu_pkg;

  typedef enum logic [2:0] {
    REG_DELTA_TRAV = 3'd0,
    REG_DELTA_OCC  = 3'd1,
    REG_PRIOR      = 3'd2,
    REG_CLIP       = 3'd3,
    REG_MIN_WEIGHT = 3'd4,
    REG_RANGE_GAIN = 3'd5,
    REG_THR_TRAV   = 3'd6,
    REG_THR_OCC    = 3'd7
  } reg_index_e;

  typedef enum logic [1:0] {
    LABEL_UNKNOWN = 2'd0,
    LABEL_FREE    = 2'd1,
    LABEL_BLOCKED = 2'd2
  } cell_label_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] RstDeltaTrav = 16'd1125;
  localparam logic [15:0] RstDeltaOcc  = 16'hFB9B;
  localparam logic [15:0] RstPrior     = 16'd0;
  localparam logic [14:0] RstClip      = 15'd6144;
  localparam logic [15:0] RstMinWeight = 16'd6554;
  localparam logic [15:0] RstRangeGain = 16'd82;
  localparam logic [15:0] RstThrTrav   = 16'd415;
  localparam logic [15:0] RstThrOcc    = 16'hFE61;

  localparam logic [15:0] WeightOne = 16'd32768;
  localparam logic [63:0] ExpStepQ31 = 64'd2081412521;

  // exp(-k/32) in q1.15, built by repeated multiplication in q1.31
  function automatic logic [15:0] exp_q15(int unsigned k);
    logic [63:0] v;
    v = 64'h0000_0000_8000_0000;
    for (int unsigned i = 0; i < k; i++) begin
      v = (v * ExpStepQ31 + 64'h0000_0000_4000_0000) >> 31;
    end
    return 16'((v + 64'd32768) >> 16);
  endfunction

endpackage

// ===== design/lgu_ram.sv =====
// ----------------------------------------------------------------------------
// lgu_ram
// simple dual port ram, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module lgu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/log_odds_grid_update.sv =====
// ----------------------------------------------------------------------------
// log_odds_grid_update
// per-cell log-odds occupancy update with distance weight, and label readout
// ----------------------------------------------------------------------------
// the result is registered in S_DONE after an update has passed S_LOAD, S_SUM,
// S_PROD, S_WGT and S_MUL, and after S_LOAD alone for a read or out-of-grid item;
// one item is in flight at a time and the next is accepted the cycle after the
// result is registered; S_DONE holds while an earlier result waits on m_axis_tready.
// after reset the count ram is swept to zero while no item is accepted;
// configuration writes are taken at any time.
module log_odds_grid_update #(
  parameter int unsigned GRID_W = 128,
  parameter int unsigned GRID_H = 128,
  parameter int unsigned EXP_TABLE_SIZE = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lgu_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [lgu_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // cell_x, cell_y, measured_traversable, robot_x, robot_y
  input  logic [55:0]                      s_axis_tdata,
  // action
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // cell_label, log_odds, observed_count, weight
  output logic [55:0]                      m_axis_tdata
);

  import lgu_pkg::*;

  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned TW = (EXP_TABLE_SIZE > 1) ? $clog2(EXP_TABLE_SIZE) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_PROD,
    S_WGT,
    S_MUL,
    S_DONE
  } state_e;

  state_e state_q;

  logic signed [15:0] delta_trav_q, delta_occ_q, prior_q, thr_trav_q, thr_occ_q;
  logic [14:0] clip_q;
  logic [15:0] min_w_q, gain_q;

  logic [AW-1:0] clr_q;
  logic [AW-1:0] addr_q;
  logic act_q, meas_q, inb_q;
  logic signed [17:0] dx_q, dy_q;
  logic [33:0] dxx_q, dyy_q;
  logic [34:0] d2_q;
  logic [50:0] prod_q;
  logic [15:0] w_q;
  logic signed [32:0] p_q;
  logic [15:0] cnt_q;
  logic signed [15:0] lo_q;

  logic out_valid_q;
  logic [1:0] out_label_q;
  logic [15:0] out_lo_q, out_cnt_q, out_w_q;

  logic [6:0] in_cx, in_cy;
  logic in_meas;
  logic signed [16:0] in_rx, in_ry;
  logic in_fire;
  logic [AW-1:0] in_addr;
  logic in_bounds;
  logic signed [17:0] dx_d, dy_d;

  logic signed [35:0] sq_x, sq_y;
  logic [51:0] rnd_sum;
  logic [24:0] idx;
  logic in_table;
  logic [15:0] exp_lut [EXP_TABLE_SIZE];
  logic [15:0] lut_w, w_hi, w_d;
  logic signed [15:0] delta_sel;
  logic signed [32:0] p_d;

  logic [32:0] p_abs;
  logic [17:0] mag;
  logic signed [18:0] inc, sum, lim_pos, lim_neg;
  logic signed [15:0] lo_new;
  logic [15:0] cnt_new;
  logic done_fire, wr_fire;

  logic cnt_we, lo_we;
  logic [AW-1:0] cnt_waddr;
  logic [15:0] cnt_wdata, cnt_rdata, lo_rdata;

  function automatic logic [1:0] label_of(logic [15:0] cnt, logic signed [15:0] lo,
                                          logic signed [15:0] thr_t,
                                          logic signed [15:0] thr_o);
    logic [1:0] lbl;
    lbl = LABEL_UNKNOWN;
    if (cnt == 16'd0) begin
      lbl = LABEL_UNKNOWN;
    end else if (lo >= thr_t) begin
      lbl = LABEL_FREE;
    end else if (lo <= thr_o) begin
      lbl = LABEL_BLOCKED;
    end
    return lbl;
  endfunction

  // input unpacking
  assign in_cx   = s_axis_tdata[6:0];
  assign in_cy   = s_axis_tdata[13:7];
  assign in_meas = s_axis_tdata[14];
  assign in_rx   = $signed(s_axis_tdata[31:15]);
  assign in_ry   = $signed(s_axis_tdata[48:32]);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign in_addr   = AW'(int'(in_cy) * GRID_W + int'(in_cx));
  assign in_bounds = (int'(in_cx) < GRID_W) && (int'(in_cy) < GRID_H);
  assign dx_d = $signed({3'b000, in_cx, 8'h80}) - 18'(in_rx);
  assign dy_d = $signed({3'b000, in_cy, 8'h80}) - 18'(in_ry);

  // distance and weight datapath
  assign sq_x = dx_q * dx_q;
  assign sq_y = dy_q * dy_q;
  assign rnd_sum = {1'b0, prod_q} + 52'h000_0000_400_0000;
  assign idx = rnd_sum[51:27];
  assign in_table = (int'(idx) < EXP_TABLE_SIZE);

  for (genvar k = 0; k < EXP_TABLE_SIZE; k++) begin : g_exp
    localparam logic [15:0] EXP_V = exp_q15(k);
    assign exp_lut[k] = EXP_V;
  end

  assign lut_w = in_table ? exp_lut[idx[TW-1:0]] : 16'd0;
  assign w_hi  = (lut_w > WeightOne) ? WeightOne : lut_w;
  assign w_d   = (w_hi < min_w_q) ? min_w_q : w_hi;

  assign delta_sel = meas_q ? delta_trav_q : delta_occ_q;
  assign p_d = $signed({1'b0, w_q}) * delta_sel;

  // round half away from zero, add and clip
  assign p_abs = p_q[32] ? 33'(-p_q) : 33'(p_q);
  assign mag   = 18'((p_abs + 33'd16384) >> 15);
  assign inc   = p_q[32] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign sum   = $signed({{3{lo_q[15]}}, lo_q}) + inc;
  assign lim_pos = $signed({4'b0000, clip_q});
  assign lim_neg = -lim_pos;
  always_comb begin
    if (sum > lim_pos) begin
      lo_new = 16'(lim_pos);
    end else if (sum < lim_neg) begin
      lo_new = 16'(lim_neg);
    end else begin
      lo_new = 16'(sum);
    end
  end
  assign cnt_new = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

  assign done_fire = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign wr_fire   = done_fire && inb_q && !act_q;

  // ram ports
  assign lo_we     = wr_fire;
  assign cnt_we    = wr_fire || (state_q == S_CLEAR);
  assign cnt_waddr = (state_q == S_CLEAR) ? clr_q : addr_q;
  assign cnt_wdata = (state_q == S_CLEAR) ? 16'd0 : cnt_new;

  lgu_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_lo_ram (
    .clk_i  (clk_i),
    .we_i   (lo_we),
    .waddr_i(addr_q),
    .wdata_i(lo_new),
    .re_i   (in_fire),
    .raddr_i(in_addr),
    .rdata_o(lo_rdata)
  );

  lgu_ram #(
    .WIDTH(16),
    .DEPTH(CELLS)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (in_fire),
    .raddr_i(in_addr),
    .rdata_o(cnt_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_trav_q <= RstDeltaTrav;
      delta_occ_q  <= RstDeltaOcc;
      prior_q      <= RstPrior;
      clip_q       <= RstClip;
      min_w_q      <= RstMinWeight;
      gain_q       <= RstRangeGain;
      thr_trav_q   <= RstThrTrav;
      thr_occ_q    <= RstThrOcc;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_index_e'(cfg_index_i))
        REG_DELTA_TRAV: delta_trav_q <= cfg_data_i;
        REG_DELTA_OCC:  delta_occ_q  <= cfg_data_i;
        REG_PRIOR:      prior_q      <= cfg_data_i;
        REG_CLIP:       clip_q       <= cfg_data_i[14:0];
        REG_MIN_WEIGHT: min_w_q      <= cfg_data_i;
        REG_RANGE_GAIN: gain_q       <= cfg_data_i;
        REG_THR_TRAV:   thr_trav_q   <= cfg_data_i;
        REG_THR_OCC:    thr_occ_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      addr_q      <= '0;
      act_q       <= 1'b0;
      meas_q      <= 1'b0;
      inb_q       <= 1'b0;
      dx_q        <= '0;
      dy_q        <= '0;
      dxx_q       <= '0;
      dyy_q       <= '0;
      d2_q        <= '0;
      prod_q      <= '0;
      w_q         <= '0;
      p_q         <= '0;
      cnt_q       <= '0;
      lo_q        <= '0;
      out_label_q <= '0;
      out_lo_q    <= '0;
      out_cnt_q   <= '0;
      out_w_q     <= '0;
    end else begin
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (clr_q == AW'(CELLS - 1)) begin
            state_q <= S_IDLE;
          end
          clr_q <= clr_q + 1'b1;
        end
        S_IDLE: begin
          if (in_fire) begin
            addr_q  <= in_addr;
            act_q   <= s_axis_tuser;
            meas_q  <= in_meas;
            inb_q   <= in_bounds;
            dx_q    <= dx_d;
            dy_q    <= dy_d;
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q   <= cnt_rdata;
          lo_q    <= (cnt_rdata != 16'd0) ? $signed(lo_rdata) : prior_q;
          dxx_q   <= sq_x[33:0];
          dyy_q   <= sq_y[33:0];
          state_q <= (inb_q && !act_q) ? S_SUM : S_DONE;
        end
        S_SUM: begin
          d2_q    <= {1'b0, dxx_q} + {1'b0, dyy_q};
          state_q <= S_PROD;
        end
        S_PROD: begin
          prod_q  <= 51'(d2_q) * 51'(gain_q);
          state_q <= S_WGT;
        end
        S_WGT: begin
          w_q     <= w_d;
          state_q <= S_MUL;
        end
        S_MUL: begin
          p_q     <= p_d;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (done_fire) begin
            if (!inb_q) begin
              out_label_q <= LABEL_UNKNOWN;
              out_lo_q    <= 16'd0;
              out_cnt_q   <= 16'd0;
              out_w_q     <= 16'd0;
            end else if (act_q) begin
              out_label_q <= label_of(cnt_q, lo_q, thr_trav_q, thr_occ_q);
              out_lo_q    <= lo_q;
              out_cnt_q   <= cnt_q;
              out_w_q     <= 16'd0;
            end else begin
              out_label_q <= label_of(cnt_new, lo_new, thr_trav_q, thr_occ_q);
              out_lo_q    <= lo_new;
              out_cnt_q   <= cnt_new;
              out_w_q     <= w_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b000000, out_w_q, out_cnt_q, out_lo_q, out_label_q};

`ifndef NO_ASSERTIONS
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared outside the finish step");

  a_write_within_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_we |-> ((lo_new <= 16'(lim_pos)) && (lo_new >= 16'(lim_neg))))
    else $error("stored log-odds outside clip bound");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_fire |-> (cnt_wdata != 16'd0))
    else $error("update wrote a zero count");

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |=> !$past(in_fire))
    else $error("item accepted during count clear");
`endif

endmodule

// ===== test/tb_log_odds_grid_update.sv =====
// ----------------------------------------------------------------------------
// tb_log_odds_grid_update
// streams update and read transfers into the log-odds grid block, mirrors the
// grid, the exp weight table and the registers in a local model, and compares
// every result transfer field by field; directed rows first, then random
// traffic under several register settings, then an unbroken run of updates on
// one cell
// ----------------------------------------------------------------------------
module tb_log_odds_grid_update;
  timeunit 1ns;
  timeprecision 1ps;

  import lgu_pkg::*;

  localparam int unsigned GridW = 128;
  localparam int unsigned ExpEntries = 256;
  localparam int unsigned PoolSize = 12;
  localparam int unsigned RandomPerPhase = 130;
  localparam int unsigned NumPhases = 5;
  localparam int unsigned StreamUpdates = 40;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned WatchdogLimit = 100000;
  localparam int unsigned MaxReports = 10;
  localparam logic [15:0] WeightOneQ15 = 16'd32768;
  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam logic ActUpdate = 1'b0;
  localparam logic ActRead   = 1'b1;
  localparam logic MeasOcc   = 1'b0;
  localparam logic MeasTrav  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic               trav;
    logic signed [16:0] robot_x;
    logic signed [16:0] robot_y;
  } cell_item_t;

  typedef struct {
    cell_label_e label;
    logic [15:0] log_odds;
    logic [15:0] count;
    logic [15:0] weight;
  } cell_result_t;

  typedef struct packed {
    logic               action;
    logic [6:0]         cell_x;
    logic [6:0]         cell_y;
    logic               trav;
    logic signed [16:0] robot_x;
    logic signed [16:0] robot_y;
    logic               known;
    cell_label_e        label;
    logic [15:0]        log_odds;
    logic [15:0]        count;
    logic [15:0]        weight;
  } directed_row_t;

  // robot position is cell * 256 + 128 at the cell centre
  directed_row_t directed_rows [21] = '{
    '{ActRead,   7'd0,   7'd0,   MeasOcc,  17'sd128,   17'sd128,   1'b1,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd0,   7'd0,   MeasTrav, 17'sd128,   17'sd128,   1'b1,
      LABEL_FREE, 16'd1125, 16'd1, 16'd32768},
    '{ActRead,   7'd0,   7'd0,   MeasTrav, 17'sd0,     17'sd0,     1'b1,
      LABEL_FREE, 16'd1125, 16'd1, 16'd0},
    '{ActUpdate, 7'd127, 7'd127, MeasOcc,  17'sd32640, 17'sd32640, 1'b1,
      LABEL_BLOCKED, 16'hFB9B, 16'd1, 16'd32768},
    '{ActUpdate, 7'd127, 7'd0,   MeasTrav, 17'h10000,  17'h10000,  1'b1,
      LABEL_UNKNOWN, 16'd225, 16'd1, 16'd6554},
    '{ActUpdate, 7'd0,   7'd127, MeasOcc,  17'sd65535, 17'h10000,  1'b1,
      LABEL_UNKNOWN, 16'hFF1F, 16'd1, 16'd6554},
    '{ActUpdate, 7'd3,   7'd3,   MeasTrav, 17'sd896,   17'sd896,   1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd3,   7'd3,   MeasTrav, 17'sd896,   17'sd896,   1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd3,   7'd3,   MeasTrav, 17'sd896,   17'sd896,   1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd3,   7'd3,   MeasTrav, 17'sd896,   17'sd896,   1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd3,   7'd3,   MeasTrav, 17'sd896,   17'sd896,   1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd3,   7'd3,   MeasTrav, 17'sd896,   17'sd896,   1'b1,
      LABEL_FREE, 16'd6144, 16'd6, 16'd32768},
    '{ActRead,   7'd3,   7'd3,   MeasOcc,  17'h1FFFF,  17'h1FFFF,  1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd10,  7'd20,  MeasTrav, 17'sd5688,  17'sd1248,  1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd64,  7'd64,  MeasOcc,  17'sd25512, 17'sd25512, 1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd1,   7'd1,   MeasTrav, 17'sd65535, 17'sd65535, 1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd126, 7'd1,   MeasOcc,  17'sd20384, 17'sd384,   1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActRead,   7'd127, 7'd127, MeasTrav, 17'sd0,     17'sd0,     1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActRead,   7'd64,  7'd64,  MeasTrav, 17'sd0,     17'sd0,     1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActUpdate, 7'd3,   7'd3,   MeasOcc,  17'h10000,  17'sd65535, 1'b0,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0},
    '{ActRead,   7'd100, 7'd50,  MeasOcc,  17'sd0,     17'sd0,     1'b1,
      LABEL_UNKNOWN, 16'd0, 16'd0, 16'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  logic [15:0]  exp_weight [ExpEntries];
  logic [15:0]  grid_log_odds [GridW * 128];
  int unsigned  grid_count [GridW * 128];
  logic [15:0]  cfg_regs [8];
  logic [15:0]  reset_settings [8];
  logic [6:0]   pool_x [PoolSize];
  logic [6:0]   pool_y [PoolSize];
  cell_result_t pending_results [$];
  cell_result_t seen_result;
  cell_result_t front_result;

  bit          idle_allowed;
  bit          idle_on;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned updates_done;
  int unsigned reads_done;
  int unsigned settings_used;
  int unsigned max_count_seen;

  log_odds_grid_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic cell_result_t predict_cell(input cell_item_t it);
    int unsigned  at;
    int unsigned  cnt;
    longint       lo;
    longint       dx;
    longint       dy;
    longint       prod;
    longint       idx;
    longint       p;
    longint       inc;
    longint       lim;
    logic [15:0]  w;
    logic [15:0]  delta;
    cell_result_t r;
    at = int'(it.cell_y) * GridW + int'(it.cell_x);
    cnt = grid_count[at];
    lo = (cnt != 0) ? longint'($signed(grid_log_odds[at]))
                    : longint'($signed(cfg_regs[REG_PRIOR]));
    w = 16'd0;
    if (it.action == ActUpdate) begin
      dx = longint'(it.cell_x) * 256 + 128 - longint'($signed(it.robot_x));
      dy = longint'(it.cell_y) * 256 + 128 - longint'($signed(it.robot_y));
      prod = (dx * dx + dy * dy) * longint'(cfg_regs[REG_RANGE_GAIN]);
      idx = (prod + (longint'(1) << 26)) >>> 27;
      w = (idx < longint'(ExpEntries)) ? exp_weight[idx] : 16'd0;
      if (w > WeightOneQ15) w = WeightOneQ15;
      if (w < cfg_regs[REG_MIN_WEIGHT]) w = cfg_regs[REG_MIN_WEIGHT];
      delta = (it.trav == MeasTrav) ? cfg_regs[REG_DELTA_TRAV] : cfg_regs[REG_DELTA_OCC];
      p = longint'(w) * longint'($signed(delta));
      // round half away from zero
      inc = (p >= 0) ? ((p + 16384) >>> 15) : -((16384 - p) >>> 15);
      lim = longint'(cfg_regs[REG_CLIP][14:0]);
      lo = lo + inc;
      if (lo > lim) lo = lim;
      if (lo < -lim) lo = -lim;
      grid_log_odds[at] = lo[15:0];
      if (cnt < int'(CountMax)) cnt++;
      grid_count[at] = cnt;
      updates_done++;
    end else begin
      reads_done++;
    end
    if (cnt == 0) r.label = LABEL_UNKNOWN;
    else if (lo >= longint'($signed(cfg_regs[REG_THR_TRAV]))) r.label = LABEL_FREE;
    else if (lo <= longint'($signed(cfg_regs[REG_THR_OCC]))) r.label = LABEL_BLOCKED;
    else r.label = LABEL_UNKNOWN;
    r.log_odds = lo[15:0];
    r.count = cnt[15:0];
    r.weight = w;
    if (cnt > max_count_seen) max_count_seen = cnt;
    return r;
  endfunction

  function automatic logic signed [16:0] near_position(input logic [6:0] cell_idx,
                                                       input int span);
    int pos;
    pos = int'(cell_idx) * 256 + 128 + int'($urandom_range(0, 2 * span)) - span;
    if (pos > 65535) pos = 65535;
    if (pos < -65536) pos = -65536;
    return 17'(pos);
  endfunction

  // mostly a small pool of cells so updates pile up, robot usually near the cell
  function automatic cell_item_t random_cell_item();
    cell_item_t  it;
    int unsigned k;
    int          span;
    k = $urandom_range(0, PoolSize - 1);
    if ($urandom_range(0, 9) < 7) begin
      it.cell_x = pool_x[k];
      it.cell_y = pool_y[k];
    end else begin
      it.cell_x = 7'($urandom_range(0, 127));
      it.cell_y = 7'($urandom_range(0, 127));
    end
    it.action = ($urandom_range(0, 9) < 3) ? ActRead : ActUpdate;
    it.trav = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: span = 2000;
      1: span = 25000;
      default: span = 0;
    endcase
    if (span == 0) begin
      it.robot_x = 17'($urandom);
      it.robot_y = 17'($urandom);
    end else begin
      it.robot_x = near_position(it.cell_x, span);
      it.robot_y = near_position(it.cell_y, span);
    end
    return it;
  endfunction

  task automatic send_cell_item(input cell_item_t it, input bit known,
                                input cell_result_t typed);
    cell_result_t want;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.action;
    s_axis_tdata  <= {7'd0, it.robot_y, it.robot_x, it.trav, it.cell_y, it.cell_x};
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_cell(it);
    if (known) want = typed;
    pending_results.insert(pending_results.size(), want);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic program_registers(input logic [15:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_regs[i] = (reg_index_e'(i) == REG_CLIP) ? {1'b0, vals[i][14:0]} : vals[i];
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // result side back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result.label    = cell_label_e'(m_axis_tdata[1:0]);
      seen_result.log_odds = m_axis_tdata[17:2];
      seen_result.count    = m_axis_tdata[33:18];
      seen_result.weight   = m_axis_tdata[49:34];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: result transfer %h with nothing pending", $realtime, m_axis_tdata);
      end else begin
        front_result = pending_results.pop_front();
        results_checked++;
        if (seen_result.label != front_result.label ||
            seen_result.log_odds != front_result.log_odds ||
            seen_result.count != front_result.count ||
            seen_result.weight != front_result.weight) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: expected label %0d log_odds %0d count %0d weight %0d, got %0d %0d %0d %0d",
                     $realtime, front_result.label, $signed(front_result.log_odds),
                     front_result.count, front_result.weight, seen_result.label,
                     $signed(seen_result.log_odds), seen_result.count, seen_result.weight);
        end
      end
    end
  end

  // counts cycles without any transfer; covers the count ram sweep after reset
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0]  v;
    logic [15:0]  vals [8];
    cell_item_t   it;
    cell_result_t typed;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = 3'd0;
    cfg_data_i = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 56'd0;
    s_axis_tuser = 1'b0;
    idle_allowed = 1'b1;
    idle_on = 1'b0;

    // exp(-k/32) in q1.15 by repeated multiplication in q1.31
    v = 64'h8000_0000;
    for (int k = 0; k < ExpEntries; k++) begin
      exp_weight[k] = 16'((v + 64'd32768) >> 16);
      v = (v * 64'd2081412521 + 64'h4000_0000) >> 31;
    end

    reset_settings = '{16'd1125, 16'hFB9B, 16'd0, 16'd6144, 16'd6554, 16'd82, 16'd415,
                       16'hFE61};
    cfg_regs = reset_settings;
    pool_x[0] = 7'd0;
    pool_y[0] = 7'd0;
    pool_x[1] = 7'd127;
    pool_y[1] = 7'd127;
    for (int i = 2; i < PoolSize; i++) begin
      pool_x[i] = 7'($urandom_range(0, 127));
      pool_y[i] = 7'($urandom_range(0, 127));
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: vals = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h7FFF,
                      16'h8000};
          // minimum weight above one, zero clip bound, zero gain
          2: vals = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'd40000, 16'h0000, 16'h8000,
                      16'h7FFF};
          3: vals = '{16'(int'($urandom_range(0, 8000)) - 4000),
                      16'(int'($urandom_range(0, 8000)) - 4000),
                      16'(int'($urandom_range(0, 4000)) - 2000),
                      16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32768)),
                      16'($urandom_range(1, 400)), 16'($urandom_range(0, 3000)),
                      16'(-int'($urandom_range(0, 3000)))};
          default: vals = '{16'd2000, 16'hF448, 16'd100, 16'd20000, 16'd1000, 16'd20, 16'd1000,
                            16'hFC18};
        endcase
        program_registers(vals);
      end
      idle_on = 1'b1;
      if (ph == 0) begin
        foreach (directed_rows[i]) begin
          it = '{directed_rows[i].action, directed_rows[i].cell_x, directed_rows[i].cell_y,
                 directed_rows[i].trav, directed_rows[i].robot_x, directed_rows[i].robot_y};
          typed.label = directed_rows[i].label;
          typed.log_odds = directed_rows[i].log_odds;
          typed.count = directed_rows[i].count;
          typed.weight = directed_rows[i].weight;
          send_cell_item(it, directed_rows[i].known, typed);
        end
      end
      for (int n = 0; n < RandomPerPhase; n++) begin
        if (n % 32 == 0) idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
        send_cell_item(random_cell_item(), 1'b0, typed);
      end
    end

    // streaming run on one cell, no idling
    drain_results();
    program_registers(reset_settings);
    idle_allowed = 1'b0;
    idle_on = 1'b0;
    for (int n = 0; n < StreamUpdates; n++) begin
      it = random_cell_item();
      it.action = ActUpdate;
      it.cell_x = 7'd77;
      it.cell_y = 7'd33;
      send_cell_item(it, 1'b0, typed);
    end
    it.action = ActRead;
    send_cell_item(it, 1'b0, typed);
    drain_results();

    $display("covered %0d updates and %0d reads over %0d register settings, top cell count %0d",
             updates_done, reads_done, settings_used + 1, max_count_seen);
    $display("%0d results compared, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
